// ===== design/utf16_newline_converter_macros.svh =====
// assertion macros for the utf16 newline converter
// used by the queue and back-end modules, no other dependencies
`ifndef UTF16_NEWLINE_CONVERTER_MACROS_SVH
`define UTF16_NEWLINE_CONVERTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define U16NL_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("u16nl: same-cycle check failed");

// next-cycle implication, disabled during reset
`define U16NL_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("u16nl: next-cycle check failed");

`endif

// ===== design/u16nl_pkg.sv =====
// shared types and constants for the utf16 newline converter
// no dependencies
`default_nettype none

package u16nl_pkg;

    // line-ending convention codes
    localparam logic [1:0] CONV_NONE = 2'd0;
    localparam logic [1:0] CONV_CRLF = 2'd1;
    localparam logic [1:0] CONV_CR   = 2'd2;
    localparam logic [1:0] CONV_LF   = 2'd3;

    // character codes
    localparam logic [7:0] CODE_CR      = 8'h0D;
    localparam logic [7:0] CODE_LF      = 8'h0A;
    localparam logic [7:0] BOM_BE_FIRST = 8'hFE;

    // register indexes on the config port
    localparam logic [1:0] REG_SOURCE = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_SWAP   = 2'd2;

    // default depth of the job queue
    localparam int QUEUE_DEPTH = 4;

    // active configuration
    typedef struct packed {
        logic [1:0] source;
        logic [1:0] target;
        logic       swap;
    } cfg_t;

    // one job: up to three output words, first byte in bits 15..8
    typedef struct packed {
        logic [1:0]       count;
        logic             last;
        logic [2:0][15:0] units;
    } job_t;

endpackage

`default_nettype wire

// ===== design/u16nl_front.sv =====
// front end: accepts input words, tracks stream state, builds output jobs
// depends on u16nl_pkg
`default_nettype none

module u16nl_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire u16nl_pkg::cfg_t cfg,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_first_byte,
    input  wire logic [7:0]      s_second_byte,
    input  wire logic            s_end_of_stream,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output u16nl_pkg::job_t      job
);

    function automatic logic [15:0] swap_unit(input logic [15:0] u, input logic sw);
        return sw ? {u[7:0], u[15:8]} : u;
    endfunction

    function automatic logic [15:0] code_unit(input logic [7:0] code, input logic be);
        return be ? {8'h00, code} : {code, 8'h00};
    endfunction

    // stream state
    logic        awaiting_reg;
    logic        be_reg;
    logic [15:0] held_reg;
    logic        held_valid_reg;
    logic        consumed_reg;

    logic        accept;
    logic [15:0] cur;
    logic        be;
    logic        hv;
    logic        pc;
    logic        hv_next;
    logic        pc_next;
    logic        copy;
    logic        crlf;
    logic        match;
    logic        line_end;
    logic [15:0] cr_t;
    logic [15:0] lf_t;
    logic [1:0]  n;

    // classify the word and build its job
    always_comb begin
        cur      = {s_first_byte, s_second_byte};
        be       = awaiting_reg ? (s_first_byte == u16nl_pkg::BOM_BE_FIRST) : be_reg;
        hv       = awaiting_reg ? 1'b0 : held_valid_reg;
        pc       = awaiting_reg ? 1'b0 : consumed_reg;
        copy     = (cfg.source == u16nl_pkg::CONV_NONE)
                   || (!cfg.swap && cfg.source == cfg.target);
        crlf     = !copy && (cfg.source == u16nl_pkg::CONV_CRLF);
        cr_t     = code_unit(u16nl_pkg::CODE_CR, be ^ cfg.swap);
        lf_t     = code_unit(u16nl_pkg::CODE_LF, be ^ cfg.swap);
        hv_next  = hv;
        pc_next  = pc;
        match    = 1'b0;
        line_end = 1'b0;
        job      = '0;
        n        = 2'd0;

        // flush a held word when leaving pair mode
        if (!crlf && hv) begin
            if (!pc) begin
                job.units[n] = swap_unit(held_reg, cfg.swap);
                n = n + 2'd1;
            end
            hv_next = 1'b0;
            pc_next = 1'b0;
        end

        if (copy) begin
            job.units[n] = swap_unit(cur, cfg.swap);
            n = n + 2'd1;
        end else if (crlf) begin
            if (hv) begin
                match = (held_reg == code_unit(u16nl_pkg::CODE_CR, be))
                        && (cur == code_unit(u16nl_pkg::CODE_LF, be));
                if (match) begin
                    case (cfg.target)
                        u16nl_pkg::CONV_CRLF: begin
                            job.units[n] = cr_t;
                            n = n + 2'd1;
                            job.units[n] = lf_t;
                            n = n + 2'd1;
                        end
                        u16nl_pkg::CONV_CR: begin
                            job.units[n] = cr_t;
                            n = n + 2'd1;
                        end
                        u16nl_pkg::CONV_LF: begin
                            job.units[n] = lf_t;
                            n = n + 2'd1;
                        end
                        default: ;
                    endcase
                    pc_next = 1'b1;
                end else if (!pc) begin
                    job.units[n] = swap_unit(held_reg, cfg.swap);
                    n = n + 2'd1;
                end else begin
                    pc_next = 1'b0;
                end
            end
            hv_next = 1'b1;
            if (s_end_of_stream && !pc_next) begin
                job.units[n] = swap_unit(cur, cfg.swap);
                n = n + 2'd1;
            end
        end else begin
            line_end = (cfg.source == u16nl_pkg::CONV_CR)
                       ? (cur == code_unit(u16nl_pkg::CODE_CR, be))
                       : (cur == code_unit(u16nl_pkg::CODE_LF, be));
            if (line_end) begin
                case (cfg.target)
                    u16nl_pkg::CONV_CRLF: begin
                        job.units[n] = cr_t;
                        n = n + 2'd1;
                        job.units[n] = lf_t;
                        n = n + 2'd1;
                    end
                    u16nl_pkg::CONV_CR: begin
                        job.units[n] = cr_t;
                        n = n + 2'd1;
                    end
                    u16nl_pkg::CONV_LF: begin
                        job.units[n] = lf_t;
                        n = n + 2'd1;
                    end
                    default: ;
                endcase
            end else begin
                job.units[n] = swap_unit(cur, cfg.swap);
                n = n + 2'd1;
            end
        end

        job.count = n;
        job.last  = s_end_of_stream;
    end

    // handshake: words that yield nothing are dropped here
    assign s_ready   = job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = s_valid && (n != 2'd0);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg   <= 1'b1;
            be_reg         <= 1'b0;
            held_valid_reg <= 1'b0;
            consumed_reg   <= 1'b0;
        end else if (accept) begin
            awaiting_reg   <= s_end_of_stream;
            be_reg         <= be;
            held_valid_reg <= s_end_of_stream ? 1'b0 : hv_next;
            consumed_reg   <= s_end_of_stream ? 1'b0 : pc_next;
        end
    end

    // held word payload
    always_ff @(posedge aclk) begin
        if (accept && crlf) begin
            held_reg <= cur;
        end
    end

endmodule

`default_nettype wire

// ===== design/u16nl_queue.sv =====
// small job queue between the front and back ends
// depends on u16nl_pkg and the macro header
`default_nettype none
`include "utf16_newline_converter_macros.svh"

module u16nl_queue #(
    parameter int DEPTH = u16nl_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire u16nl_pkg::job_t in_job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output u16nl_pkg::job_t      out_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16nl_pkg::job_t    store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_job   = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_job;
        end
    end

    // count follows pushes and no pushed job is empty; only full queues refuse
    `U16NL_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `U16NL_ASSERT_NOW(a_no_empty_job, aclk, aresetn, push, in_job.count != 2'd0)

endmodule

`default_nettype wire

// ===== design/u16nl_back.sv =====
// back end: plays out the words of each job, one per cycle while m_ready is high
// depends on u16nl_pkg and the macro header
`default_nettype none
`include "utf16_newline_converter_macros.svh"

module u16nl_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            job_valid,
    output logic                 job_ready,
    input  wire u16nl_pkg::job_t job,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [7:0]           m_out_first_byte,
    output logic [7:0]           m_out_second_byte,
    output logic                 m_out_last
);

    u16nl_pkg::job_t job_reg;
    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic            last_unit;
    logic            advance;
    logic            load;
    logic [15:0]     unit;

    assign last_unit = (idx_reg == job_reg.count - 2'd1);
    assign advance   = !busy_reg || (m_ready && last_unit);
    assign job_ready = advance;
    assign load      = advance && job_valid;

    // output word from the current job
    assign unit              = job_reg.units[idx_reg];
    assign m_valid           = busy_reg;
    assign m_out_first_byte  = unit[15:8];
    assign m_out_second_byte = unit[7:0];
    assign m_out_last        = job_reg.last && last_unit;

    // job sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (advance) begin
            busy_reg <= 1'b0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // current job payload
    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job;
        end
    end

    // word index stays inside the job being played out, and a load starts at its first word
    `U16NL_ASSERT_NOW(a_idx_in_job, aclk, aresetn, busy_reg, idx_reg < job_reg.count)
    `U16NL_ASSERT_NEXT(a_load_starts, aclk, aresetn, load, busy_reg && idx_reg == 2'd0)

endmodule

`default_nettype wire

// ===== design/utf16_newline_converter.sv =====
// utf16 newline converter top level: config registers, front, queue, back
// depends on u16nl_pkg, u16nl_front, u16nl_queue, u16nl_back
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------
//   input     s_valid/s_ready    s_first_byte, s_second_byte, s_end_of_stream
//   output    m_valid/m_ready    m_out_first_byte, m_out_second_byte, m_out_last
//   config    psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// one input word per cycle while the queue has room; a word is classified and
// made a job as it is accepted, then registered in the queue and in the back
// end's job register. the back end emits one output word per cycle while
// m_ready is high, so a job of two or three words holds the output until they
// are out. the job queue (QUEUE_DEPTH entries) absorbs bursts and output stalls.
// reset is synchronous and clears control state only; no clearing pass.
`default_nettype none

module utf16_newline_converter #(
    parameter int QUEUE_DEPTH = u16nl_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input words
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_first_byte,
    input  wire logic [7:0]  s_second_byte,
    input  wire logic        s_end_of_stream,
    // output words
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_first_byte,
    output logic [7:0]       m_out_second_byte,
    output logic             m_out_last
);

    u16nl_pkg::cfg_t cfg_reg;
    logic            cfg_write;
    logic [1:0]      reg_idx;

    u16nl_pkg::job_t front_job;
    logic            front_valid;
    logic            front_ready;
    u16nl_pkg::job_t back_job;
    logic            back_valid;
    logic            back_ready;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                u16nl_pkg::REG_SOURCE: cfg_reg.source <= pwdata[1:0];
                u16nl_pkg::REG_TARGET: cfg_reg.target <= pwdata[1:0];
                u16nl_pkg::REG_SWAP:   cfg_reg.swap   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        case (reg_idx)
            u16nl_pkg::REG_SOURCE: prdata = {30'd0, cfg_reg.source};
            u16nl_pkg::REG_TARGET: prdata = {30'd0, cfg_reg.target};
            u16nl_pkg::REG_SWAP:   prdata = {31'd0, cfg_reg.swap};
            default:               prdata = 32'd0;
        endcase
    end

    u16nl_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_byte    (s_first_byte),
        .s_second_byte   (s_second_byte),
        .s_end_of_stream (s_end_of_stream),
        .job_valid       (front_valid),
        .job_ready       (front_ready),
        .job             (front_job)
    );

    u16nl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    u16nl_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .job_valid         (back_valid),
        .job_ready         (back_ready),
        .job               (back_job),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_first_byte  (m_out_first_byte),
        .m_out_second_byte (m_out_second_byte),
        .m_out_last        (m_out_last)
    );

endmodule

`default_nettype wire
